@@ rtl/core/brb_pkg.sv @@
// ---------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer unit.
// ---------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned COUNT_W = 11;   // ring length: 10-bit size plus a small gap
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [LEN_W-1:0] BUF_SIZE_RESET = 10'd1023;

  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_DISCARD = 3'd2,
    REQ_READ    = 3'd3,
    REQ_WRITE   = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic               first_byte;
    logic [LEN_W-1:0]   req_len;
    logic [LEN_W-1:0]   offset;
    logic [BYTE_W-1:0]  data_in;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               rd_flag;     // data_out comes from the store
    logic [LEN_W-1:0]   used_count;
    logic [LEN_W-1:0]   free_count;
  } result_t;

endpackage

@@ rtl/core/brb_store.sv @@
// ---------------------------------------------------------------------------
// brb_store
// Single-port byte store with registered read data.
// ---------------------------------------------------------------------------
module brb_store #(
  parameter int unsigned STORE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      rd_en,
  input  logic [AW-1:0]             addr,
  input  logic [brb_pkg::BYTE_W-1:0] wr_data,
  output logic [brb_pkg::BYTE_W-1:0] rd_data
);

  logic [brb_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
  logic [brb_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/brb_ctrl.sv @@
// ---------------------------------------------------------------------------
// brb_ctrl
// Pointer state, length checks and per-step decision for the ring buffer.
// ---------------------------------------------------------------------------
module brb_ctrl #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned FULL_GAP    = 1,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brb_pkg::LEN_W-1:0]  cfg_size,
  input  logic                       step_en,
  input  brb_pkg::item_t             item,
  output brb_pkg::result_t           result,
  output logic                       wr_en,
  output logic                       rd_en,
  output logic [AW-1:0]              mem_addr,
  output logic [brb_pkg::BYTE_W-1:0] wr_data
);

  localparam int unsigned SW = (AW > brb_pkg::COUNT_W) ? AW : brb_pkg::COUNT_W;
  localparam int unsigned XW = SW + 1;
  localparam int CAP_MAX  = (STORE_DEPTH > FULL_GAP) ? int'(STORE_DEPTH - FULL_GAP) : 0;
  localparam int CAP_LIM  = (CAP_MAX > 1023) ? 1023 : CAP_MAX;
  localparam int RST_CAP  = (1023 + FULL_GAP > STORE_DEPTH) ? CAP_LIM : 1023;

  logic [AW-1:0]                head_r, head_nxt;
  logic [AW-1:0]                tail_r, tail_nxt;
  logic                         rej_r, rej_nxt;
  logic [brb_pkg::COUNT_W-1:0]  cap_r, ring_r;
  logic [brb_pkg::COUNT_W-1:0]  cfg_cap;

  logic [XW-1:0] head_x, tail_x, ring_x, cap_x, len_x, off_x;
  logic [XW-1:0] used_x, free_x, used_after;
  logic [XW-1:0] head_inc, tail_inc, head_len, head_off;
  logic          rej_chk, acc, rd_flag;

  // clamp the usable size so the ring fits the store
  always_comb begin
    if (XW'(cfg_size) + XW'(FULL_GAP) > XW'(STORE_DEPTH)) begin
      cfg_cap = brb_pkg::COUNT_W'(CAP_LIM);
    end else begin
      cfg_cap = brb_pkg::COUNT_W'(cfg_size);
    end
  end

  assign head_x = XW'(head_r);
  assign tail_x = XW'(tail_r);
  assign ring_x = XW'(ring_r);
  assign cap_x  = XW'(cap_r);
  assign len_x  = XW'(item.req_len);
  assign off_x  = XW'(item.offset);

  assign used_x = (tail_x >= head_x) ? (tail_x - head_x) : (ring_x + tail_x - head_x);
  assign free_x = cap_x - used_x;

  assign head_inc = (head_x + 1'b1 == ring_x) ? '0 : head_x + 1'b1;
  assign tail_inc = (tail_x + 1'b1 == ring_x) ? '0 : tail_x + 1'b1;
  // each sum stays below twice the ring length while the length or offset is below it
  assign head_len = (head_x + len_x >= ring_x) ? head_x + len_x - ring_x : head_x + len_x;
  assign head_off = (head_x + off_x >= ring_x) ? head_x + off_x - ring_x : head_x + off_x;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    rej_nxt    = rej_r;
    rej_chk    = rej_r;
    acc        = 1'b0;
    rd_flag    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    mem_addr   = head_r;
    used_after = used_x;
    case (item.req_type)
      brb_pkg::REQ_PUSH: begin
        rej_chk = item.first_byte ? (free_x < len_x) : rej_r;
        rej_nxt = rej_chk;
        if (!rej_chk && free_x != '0) begin
          acc        = 1'b1;
          wr_en      = step_en;
          mem_addr   = tail_r;
          tail_nxt   = AW'(tail_inc);
          used_after = used_x + 1'b1;
        end
      end
      brb_pkg::REQ_POP: begin
        rej_chk = item.first_byte ? (used_x < len_x) : rej_r;
        rej_nxt = rej_chk;
        if (!rej_chk && used_x != '0) begin
          acc        = 1'b1;
          rd_flag    = 1'b1;
          rd_en      = step_en;
          head_nxt   = AW'(head_inc);
          used_after = used_x - 1'b1;
        end
      end
      brb_pkg::REQ_DISCARD: begin
        if (used_x >= len_x) begin
          acc        = 1'b1;
          head_nxt   = AW'(head_len);
          used_after = used_x - len_x;
        end
      end
      brb_pkg::REQ_READ, brb_pkg::REQ_WRITE: begin
        rej_chk = item.first_byte ? (used_x < off_x + len_x) : rej_r;
        rej_nxt = rej_chk;
        if (!rej_chk && off_x < used_x) begin
          acc      = 1'b1;
          mem_addr = AW'(head_off);
          if (item.req_type == brb_pkg::REQ_READ) begin
            rd_flag = 1'b1;
            rd_en   = step_en;
          end else begin
            wr_en   = step_en;
          end
        end
      end
      brb_pkg::REQ_CLEAR: begin
        acc        = 1'b1;
        head_nxt   = '0;
        tail_nxt   = '0;
        rej_nxt    = 1'b0;
        used_after = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr_data = item.data_in;

  always_comb begin
    result.accepted   = acc;
    result.rd_flag    = rd_flag;
    result.used_count = used_after[brb_pkg::LEN_W-1:0];
    result.free_count = brb_pkg::LEN_W'(cap_x - used_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      rej_r  <= 1'b0;
      cap_r  <= brb_pkg::COUNT_W'(RST_CAP);
      ring_r <= brb_pkg::COUNT_W'(RST_CAP + FULL_GAP);
    end else if (cfg_we) begin
      // a new size empties the ring
      head_r <= '0;
      tail_r <= '0;
      rej_r  <= 1'b0;
      cap_r  <= cfg_cap;
      ring_r <= cfg_cap + brb_pkg::COUNT_W'(FULL_GAP);
    end else if (step_en) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      rej_r  <= rej_nxt;
    end
  end

endmodule

@@ rtl/core/byte_ring_buffer_unit.sv @@
// Path: an input beat passes the input register, then the result register with
//   the store read data registered beside it, before it leaves as a result beat.
// Throughput: one item per cycle while the result stream is not stalled; each
//   step makes at most one access on the single store port and one pointer update.
// Reset: synchronous, active low; clears pointers, reject flag and valids, buf_size
//   returns to 1023, or less if the store cannot hold it. Store contents are not cleared.
// ---------------------------------------------------------------------------
// byte_ring_buffer_unit
// Byte FIFO on a circular store with offset access, discard and clear.
// ---------------------------------------------------------------------------
module byte_ring_buffer_unit #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned FULL_GAP    = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: buf_size[9:0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // req_len[9:0], offset[19:10], data_in[27:20]
  input  logic [3:0]  in_tuser,   // req_type[2:0], first_byte[3]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // accepted[0], data_out[8:1], used_count[18:9],
                                  // free_count[28:19]
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic                      s0_v_r;
  brb_pkg::item_t            s0_item_r;
  logic                      out_v_r;
  brb_pkg::result_t          out_res_r;
  brb_pkg::result_t          step_res;
  logic                      adv;
  logic                      in_acc;
  logic                      cfg_we;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             mem_addr;
  logic [brb_pkg::BYTE_W-1:0] wr_data, rd_data, data_out;

  assign cfg_tready = 1'b1;
  assign cfg_we     = cfg_tvalid && cfg_tready;

  // advance the held item when the result register is free or draining
  assign adv       = s0_v_r && (!out_v_r || out_tready);
  assign in_tready = !s0_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_acc) begin
      s0_v_r <= 1'b1;
    end else if (adv) begin
      s0_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_item_r.req_type   <= brb_pkg::req_type_t'(in_tuser[2:0]);
      s0_item_r.first_byte <= in_tuser[3];
      s0_item_r.req_len    <= in_tdata[9:0];
      s0_item_r.offset     <= in_tdata[19:10];
      s0_item_r.data_in    <= in_tdata[27:20];
    end
  end

  brb_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .FULL_GAP    (FULL_GAP)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_size (cfg_tdata[9:0]),
    .step_en  (adv),
    .item     (s0_item_r),
    .result   (step_res),
    .wr_en    (wr_en),
    .rd_en    (rd_en),
    .mem_addr (mem_addr),
    .wr_data  (wr_data)
  );

  brb_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .rd_en   (rd_en),
    .addr    (mem_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign data_out   = out_res_r.rd_flag ? rd_data : '0;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_res_r.free_count, out_res_r.used_count,
                       data_out, out_res_r.accepted};

endmodule

@@ rtl/core/brb_checker.sv @@
// ---------------------------------------------------------------------------
// brb_checker
// Port-level checks on the byte ring buffer unit, bound to the top level.
// ---------------------------------------------------------------------------
module brb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // rejected steps never carry data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("rejected step returned data");

  // used plus free never exceeds the largest usable size
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[18:9]} + {1'b0, out_tdata[28:19]}) <= 11'd1023)
    else $error("used and free counts inconsistent");

  // reset drains the result side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // reset leaves the input side ready
  a_in_ready_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
